@@ sv/assert_macros.svh @@
// assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("%m: assertion failed");

`define ASSERT_NEXT(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("%m: assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst, prop)

`define ASSERT_NEXT(lbl, clk, rst, pre, post)

`endif

`endif

@@ sv/kc3_pkg.sv @@
package kc3_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int ADDR_W      = $clog2(MAX_WIDTH);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int ROW_W       = 13;
  localparam int PEND_W      = 11;

  localparam logic [1:0] REG_KERNEL_MODE  = 2'd0;
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd1;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd2;

  localparam logic [1:0] MODE_BLUR    = 2'd0;
  localparam logic [1:0] MODE_SHARPEN = 2'd1;
  localparam logic [1:0] MODE_SOBEL   = 2'd2;

  localparam logic [10:0] WIDTH_RESET  = 11'd320;
  localparam logic [11:0] HEIGHT_RESET = 12'd240;

  typedef struct packed {
    logic [7:0] pixel;
    logic       flush;
  } in_t;

  typedef struct packed {
    logic signed [14:0] filtered;
    logic [7:0]         display_level;
    logic               frame_end;
  } out_t;

  typedef struct packed {
    logic [10:0] frame_width;
    logic [11:0] frame_height;
  } geom_t;

  typedef struct packed {
    logic [2:0][2:0][7:0] taps;
    logic                 frame_end;
  } win_t;

endpackage

@@ sv/kc3_front.sv @@
module kc3_front import kc3_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  accept,
  input  in_t   item,
  input  geom_t geom,
  output logic  push,
  output win_t  entry
);

  logic [ADDR_W-1:0] column_count;
  logic [ROW_W-1:0]  row_count;
  logic [PEND_W-1:0] pending_count;

  logic [10:0]       wid;
  logic [11:0]       hgt;
  logic              draining;
  logic              take;
  logic [10:0]       x_ext;
  logic              row_end;
  logic              last_row;
  logic              first_col;
  logic              emit;
  logic              drain_end;
  logic [10:0]       ex;
  logic [ROW_W-1:0]  ey;
  logic [2:0][11:0]  ex_c;
  logic [2:0][13:0]  ey_r;
  logic [2:0]        col_ok;
  logic [2:0]        row_ok;
  logic [7:0]        pix_eff;

  logic              s1_valid;
  logic [ADDR_W-1:0] s1_addr;
  logic [7:0]        s1_pix;
  logic              s1_emit;
  logic              s1_fend;
  logic              s1_clear;
  logic [2:0]        s1_row_ok;
  logic [2:0]        s1_col_ok;

  logic [7:0]        line_near [MAX_WIDTH];
  logic [7:0]        line_far  [MAX_WIDTH];
  logic [7:0]        q_near;
  logic [7:0]        q_far;
  logic              byp_hit;
  logic [7:0]        byp_near;
  logic [7:0]        byp_far;
  logic [7:0]        up1;
  logic [7:0]        up2;

  logic [2:0][2:0][7:0] taps;
  logic [2:0][2:0][7:0] tap_new;
  logic [2:0][7:0]      col_in;

  always_comb begin
    if (geom.frame_width == 11'd0) begin
      wid = 11'd1;
    end else if (geom.frame_width > 11'(MAX_WIDTH)) begin
      wid = 11'(MAX_WIDTH);
    end else begin
      wid = geom.frame_width;
    end
    hgt = (geom.frame_height == 12'd0) ? 12'd1 : geom.frame_height;
  end

  assign draining  = pending_count != '0;
  assign take      = accept && !(item.flush && !draining);
  assign pix_eff   = draining ? 8'd0 : item.pixel;
  assign x_ext     = 11'(column_count);
  assign row_end   = (x_ext + 11'd1) >= wid;
  assign last_row  = (row_count + ROW_W'(1)) >= ROW_W'(hgt);
  assign first_col = (column_count == '0) && (row_count >= ROW_W'(2));
  assign emit      = first_col || ((column_count != '0) && (row_count != '0));
  assign drain_end = draining && (pending_count == PEND_W'(1));

  // first column of a row closes the previous row's last centre
  assign ex = first_col ? wid : x_ext;
  assign ey = first_col ? row_count - ROW_W'(1) : row_count;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ex_c[i]   = 12'(ex) + 12'(i);
      ey_r[i]   = 14'(ey) + 14'(i);
      col_ok[i] = (ex_c[i] >= 12'd2) && (ex_c[i] < (12'(wid) + 12'd2));
      row_ok[i] = (ey_r[i] >= 14'd2) && (ey_r[i] < (14'(hgt) + 14'd2));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count  <= '0;
      row_count     <= '0;
      pending_count <= '0;
    end else if (take) begin
      if (drain_end) begin
        column_count <= '0;
        row_count    <= '0;
      end else begin
        column_count <= row_end ? '0 : column_count + ADDR_W'(1);
        row_count    <= row_end ? row_count + ROW_W'(1) : row_count;
      end
      if (draining) begin
        pending_count <= pending_count - PEND_W'(1);
      end else if (row_end && last_row) begin
        pending_count <= PEND_W'(wid) + PEND_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_addr   <= column_count;
      s1_pix    <= pix_eff;
      s1_emit   <= emit;
      s1_fend   <= drain_end && emit;
      s1_clear  <= drain_end;
      s1_row_ok <= row_ok;
      s1_col_ok <= col_ok;
    end
  end

  // line stores: read on transfer, written in the following cycle
  always_ff @(posedge clk) begin
    if (s1_valid) begin
      line_near[s1_addr] <= s1_pix;
      line_far[s1_addr]  <= up1;
    end
    if (take) begin
      q_near <= line_near[column_count];
      q_far  <= line_far[column_count];
    end
  end

  // same-address read and write on one-pixel lines
  always_ff @(posedge clk) begin
    if (rst) begin
      byp_hit <= 1'b0;
    end else begin
      byp_hit <= take && s1_valid && (s1_addr == column_count);
    end
  end

  always_ff @(posedge clk) begin
    byp_near <= s1_pix;
    byp_far  <= up1;
  end

  assign up1 = byp_hit ? byp_near : q_near;
  assign up2 = byp_hit ? byp_far : q_far;

  assign col_in[0] = up2;
  assign col_in[1] = up1;
  assign col_in[2] = s1_pix;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      tap_new[r][0] = taps[r][1];
      tap_new[r][1] = taps[r][2];
      tap_new[r][2] = col_in[r];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      taps <= '0;
    end else if (s1_valid) begin
      taps <= s1_clear ? '0 : tap_new;
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        entry.taps[r][c] = (s1_row_ok[r] && s1_col_ok[c]) ? tap_new[r][c] : 8'd0;
      end
    end
    entry.frame_end = s1_fend;
  end

  assign push = s1_valid && s1_emit;

endmodule

@@ sv/kc3_queue.sv @@
module kc3_queue import kc3_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  win_t              wr_entry,
  input  logic              pop,
  output win_t              head,
  output logic [QLVL_W-1:0] level
);

  win_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      level <= level + QLVL_W'(push) - QLVL_W'(pop);
    end
  end

  assign head = slots[rd_ptr];

endmodule

@@ sv/kc3_back.sv @@
module kc3_back import kc3_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] mode,
  input  win_t       head,
  input  logic       head_valid,
  output logic       head_take,
  input  logic       pop,
  output logic       empty,
  output out_t       result
);

  logic signed [15:0] a00, n, w, c, e, s, a22;
  logic signed [15:0] blur;
  logic signed [15:0] sharp;
  logic signed [15:0] gsum;
  logic signed [15:0] gabs;
  logic signed [15:0] f;
  logic [7:0]         disp;
  logic               out_valid;

  assign a00 = $signed({8'd0, head.taps[0][0]});
  assign n   = $signed({8'd0, head.taps[0][1]});
  assign w   = $signed({8'd0, head.taps[1][0]});
  assign c   = $signed({8'd0, head.taps[1][1]});
  assign e   = $signed({8'd0, head.taps[1][2]});
  assign s   = $signed({8'd0, head.taps[2][1]});
  assign a22 = $signed({8'd0, head.taps[2][2]});

  assign blur  = (c <<< 2) + n + s + e + w;
  assign sharp = ((c <<< 2) + c - n - s - e - w) <<< 3;
  assign gsum  = ((e + s + a22) - (a00 + n + w)) <<< 1;
  assign gabs  = gsum[15] ? -gsum : gsum;

  always_comb begin
    case (mode)
      MODE_BLUR:    f = blur;
      MODE_SHARPEN: f = sharp;
      MODE_SOBEL:   f = gabs <<< 2;
      default:      f = blur;
    endcase
  end

  always_comb begin
    if (f[15]) begin
      disp = 8'd0;
    end else if (f[15:3] > 13'd255) begin
      disp = 8'd255;
    end else begin
      disp = f[10:3];
    end
  end

  assign head_take = head_valid && (!out_valid || pop);
  assign empty     = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (head_take) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (head_take) begin
      result.filtered      <= f[14:0];
      result.display_level <= disp;
      result.frame_end     <= head.frame_end;
    end
  end

endmodule

@@ sv/kernel_convolution_3x3.sv @@
// channel   signals                              transfer when
// input     item (pixel, flush), push, full      push && !full
// result    result (filtered, level, end), pop   pop && !empty
// config    write_en, write_index, write_data    write_en
//
// one item per cycle while full is low; results pass window stage, queue and output register
// the line stores take one read and one write a cycle, read the cycle before the window update
// a four-entry queue parts the window front from the kernel and output register
// full rises when the queue plus the item in the window stage would fill it
// synchronous reset clears counters, window and queue; line stores are not cleared
`include "assert_macros.svh"

module kernel_convolution_3x3 import kc3_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  in_t         item,
  output logic        empty,
  input  logic        pop,
  output out_t        result,
  input  logic        write_en,
  input  logic [1:0]  write_index,
  input  logic [11:0] write_data
);

  logic [1:0]        kernel_mode;
  logic [10:0]       frame_width;
  logic [11:0]       frame_height;
  geom_t             geom;
  logic              accept;
  logic              q_push;
  win_t              q_entry;
  win_t              q_head;
  logic [QLVL_W-1:0] q_level;
  logic              q_pop;
  logic [QLVL_W:0]   level_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_mode  <= MODE_BLUR;
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
    end else if (write_en) begin
      case (write_index)
        REG_KERNEL_MODE:  kernel_mode  <= write_data[1:0];
        REG_FRAME_WIDTH:  frame_width  <= write_data[10:0];
        REG_FRAME_HEIGHT: frame_height <= write_data;
        default: ;
      endcase
    end
  end

  assign geom.frame_width  = frame_width;
  assign geom.frame_height = frame_height;

  assign level_sum = (QLVL_W + 1)'(q_level) + (QLVL_W + 1)'(q_push);
  assign full      = level_sum >= (QLVL_W + 1)'(QUEUE_DEPTH);
  assign accept    = push && !full;

  kc3_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (item),
    .geom   (geom),
    .push   (q_push),
    .entry  (q_entry)
  );

  kc3_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wr_entry (q_entry),
    .pop      (q_pop),
    .head     (q_head),
    .level    (q_level)
  );

  kc3_back u_back (
    .clk        (clk),
    .rst        (rst),
    .mode       (kernel_mode),
    .head       (q_head),
    .head_valid (q_level != '0),
    .head_take  (q_pop),
    .pop        (pop),
    .empty      (empty),
    .result     (result)
  );

  `ASSERT_ALWAYS(a_queue_room, clk, rst, !q_push || (q_level < QLVL_W'(QUEUE_DEPTH)))
  `ASSERT_NEXT(a_back_refill, clk, rst, (q_level != '0) && empty, !empty)
  `ASSERT_ALWAYS(a_push_after_transfer, clk, rst, !q_push || $past(push && !full))

endmodule

@@ dv/kernel_convolution_3x3_tb.sv @@
module kernel_convolution_3x3_tb;
  import kc3_pkg::*;

  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS = 250;

  typedef enum int {PIX_RANDOM, PIX_CHECKER, PIX_INV_CHECKER, PIX_WHITE} fill_t;
  typedef bit [2:0][2:0][7:0] taps_t;

  bit          clk;
  logic        rst;
  bit          push;
  logic        full;
  in_t         item;
  logic        empty;
  bit          pop;
  out_t        result;
  bit          write_en;
  bit   [1:0]  write_index;
  bit   [11:0] write_data;

  kernel_convolution_3x3 dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .item(item),
    .empty(empty),
    .pop(pop),
    .result(result),
    .write_en(write_en),
    .write_index(write_index),
    .write_data(write_data)
  );

  // expected-value model state
  logic [1:0]  cfg_mode;
  logic [10:0] cfg_width;
  logic [11:0] cfg_height;
  bit   [7:0]  row_store [2*MAX_WIDTH];
  taps_t       window;
  int unsigned col_pos;
  int unsigned row_pos;
  int unsigned drain_left;
  out_t        pending_results [$];

  int unsigned pixels_taken;
  int unsigned stream_items;
  int unsigned mismatches;
  int unsigned cycle_count;
  int unsigned burst_left;
  int unsigned stall_left;
  int unsigned stall_style;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int kernel_sum(taps_t w, int cx, int cy, int wid, int hgt);
    int v [3][3];
    int g;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (cx + c - 1 >= 0 && cx + c - 1 < wid && cy + r - 1 >= 0 && cy + r - 1 < hgt)
          v[r][c] = int'(w[r][c]);
        else
          v[r][c] = 0;
      end
    end
    case (cfg_mode)
      MODE_SHARPEN: return 8 * (5 * v[1][1] - v[0][1] - v[2][1] - v[1][0] - v[1][2]);
      MODE_SOBEL: begin
        g = -2 * v[0][0] - 2 * v[0][1] - 2 * v[1][0] + 2 * v[1][2] + 2 * v[2][1] + 2 * v[2][2];
        return 4 * (g < 0 ? -g : g);
      end
      default: return 4 * v[1][1] + v[0][1] + v[2][1] + v[1][0] + v[1][2];
    endcase
  endfunction

  function automatic void filter_pixel(in_t it);
    int unsigned wid, hgt, x, y, idx;
    bit          draining, emit, fend;
    bit   [7:0]  pix, up1, up2;
    taps_t       edge_win;
    int          f, level;
    out_t        want;
    wid = (cfg_width == 0) ? 1 : cfg_width;
    if (wid > MAX_WIDTH) wid = MAX_WIDTH;
    hgt = (cfg_height == 0) ? 1 : cfg_height;
    draining = drain_left != 0;
    if (!draining && it.flush) return;
    pix = draining ? 8'd0 : it.pixel;
    x = col_pos;
    y = row_pos;
    emit = 0;
    fend = 0;
    f = 0;
    // last centre of the previous row, zero column on its right
    if (x == 0 && y >= 2) begin
      edge_win = '0;
      for (int r = 0; r < 3; r++) begin
        edge_win[r][0] = window[r][1];
        edge_win[r][1] = window[r][2];
      end
      f = kernel_sum(edge_win, wid - 1, y - 2, wid, hgt);
      emit = 1;
    end
    idx = x % MAX_WIDTH;
    up1 = row_store[idx];
    up2 = row_store[MAX_WIDTH + idx];
    row_store[MAX_WIDTH + idx] = up1;
    row_store[idx] = pix;
    for (int r = 0; r < 3; r++) begin
      window[r][0] = window[r][1];
      window[r][1] = window[r][2];
    end
    window[0][2] = up2;
    window[1][2] = up1;
    window[2][2] = pix;
    if (x >= 1 && y >= 1) begin
      f = kernel_sum(window, x - 1, y - 1, wid, hgt);
      emit = 1;
    end
    if (x + 1 >= wid) begin
      col_pos = 0;
      row_pos = y + 1;
    end else begin
      col_pos = x + 1;
    end
    if (draining) begin
      drain_left--;
      if (drain_left == 0) begin
        fend = emit;
        col_pos = 0;
        row_pos = 0;
        window = '0;
      end
    end else if (x + 1 >= wid && y + 1 >= hgt) begin
      drain_left = wid + 1;
    end
    if (!emit) return;
    level = (f < 0) ? 0 : (f >>> 3);
    if (level > 255) level = 255;
    want.filtered = f[14:0];
    want.display_level = level[7:0];
    want.frame_end = fend;
    pending_results = {pending_results, want};
  endfunction

  function automatic void compare_result(out_t got);
    out_t want;
    if (pending_results.size() == 0) begin
      if (mismatches < 10)
        $display("unexpected result: filtered %0d level %0d end %0b",
                 got.filtered, got.display_level, got.frame_end);
      mismatches++;
      return;
    end
    want = pending_results.pop_front();
    if (got.filtered !== want.filtered || got.display_level !== want.display_level ||
        got.frame_end !== want.frame_end) begin
      if (mismatches < 10)
        $display("mismatch: want filtered %0d level %0d end %0b, got filtered %0d level %0d end %0b",
                 want.filtered, want.display_level, want.frame_end,
                 got.filtered, got.display_level, got.frame_end);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
    if (rst) begin
      cfg_mode = MODE_BLUR;
      cfg_width = WIDTH_RESET;
      cfg_height = HEIGHT_RESET;
      window = '0;
      col_pos = 0;
      row_pos = 0;
      drain_left = 0;
    end else begin
      if (write_en) begin
        case (write_index)
          REG_KERNEL_MODE:  cfg_mode = write_data[1:0];
          REG_FRAME_WIDTH:  cfg_width = write_data[10:0];
          REG_FRAME_HEIGHT: cfg_height = write_data[11:0];
          default: ;
        endcase
      end
      if (push && !full) begin
        filter_pixel(item);
        pixels_taken++;
      end
      if (pop && !empty) compare_result(result);
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_style = $urandom_range(0, 3);
      stall_left = $urandom_range(4, 60);
    end
    stall_left--;
    case (stall_style)
      0: pop <= 1'b1;
      1: pop <= 1'($urandom_range(0, 1));
      2: pop <= ($urandom_range(0, 3) == 0);
      default: pop <= (stall_left < 4);
    endcase
  end

  task automatic send_item(input logic [7:0] px, input logic fl);
    int unsigned seen;
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 60);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        push <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    item <= '{pixel: px, flush: fl};
    push <= 1'b1;
    seen = pixels_taken;
    do @(negedge clk); while (pixels_taken == seen);
  endtask

  task automatic settle();
    push <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic program_frame(input logic [1:0] mode, input logic [11:0] wdata,
                               input logic [11:0] hdata);
    logic [11:0] d;
    d = 12'($urandom_range(0, 4095));
    d[1:0] = mode;
    write_en <= 1'b1;
    write_index <= REG_KERNEL_MODE;
    write_data <= d;
    @(negedge clk);
    write_index <= REG_FRAME_WIDTH;
    write_data <= wdata;
    @(negedge clk);
    write_index <= REG_FRAME_HEIGHT;
    write_data <= hdata;
    @(negedge clk);
    write_en <= 1'b0;
  endtask

  function automatic logic [7:0] fill_pixel(fill_t fill, int x, int y);
    case (fill)
      PIX_CHECKER:     return ((x + y) % 2 == 0) ? 8'd255 : 8'd0;
      PIX_INV_CHECKER: return ((x + y) % 2 == 0) ? 8'd0 : 8'd255;
      PIX_WHITE:       return 8'd255;
      default:         return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic run_frame(input logic [1:0] mode, input logic [11:0] wdata,
                           input logic [11:0] hdata, input fill_t fill, input bit noisy);
    int unsigned wid, hgt;
    wid = (wdata[10:0] == 0) ? 1 : wdata[10:0];
    if (wid > MAX_WIDTH) wid = MAX_WIDTH;
    hgt = (hdata == 0) ? 1 : hdata;
    program_frame(mode, wdata, hdata);
    // stray flushes outside a drain are dropped
    if (noisy) repeat ($urandom_range(1, 3)) send_item(8'($urandom_range(0, 255)), 1'b1);
    for (int y = 0; y < hgt; y++)
      for (int x = 0; x < wid; x++)
        send_item(fill_pixel(fill, x, y), 1'b0);
    for (int k = 0; k <= wid; k++) begin
      if (noisy && $urandom_range(0, 2) == 0) send_item(8'($urandom_range(0, 255)), 1'b0);
      else send_item(8'($urandom_range(0, 255)), 1'b1);
    end
    stream_items += wid * hgt + wid + 1;
    settle();
  endtask

  function automatic logic [11:0] width_word(int w);
    logic [11:0] d;
    d = 12'(w);
    d[11] = 1'($urandom_range(0, 1));
    return d;
  endfunction

  // widest frame, width register above the limit
  task automatic test_full_width();
    run_frame(MODE_BLUR, 12'hFFF, 12'd1, PIX_RANDOM, 1'b0);
  endtask

  task automatic test_extreme_levels();
    run_frame(MODE_SHARPEN, width_word(3), 12'd3, PIX_CHECKER, 1'b0);
    run_frame(MODE_SHARPEN, width_word(3), 12'd3, PIX_INV_CHECKER, 1'b0);
    run_frame(MODE_BLUR, width_word(3), 12'd3, PIX_WHITE, 1'b0);
    run_frame(MODE_SOBEL, width_word(3), 12'd3, PIX_WHITE, 1'b0);
    run_frame(MODE_SOBEL, width_word(4), 12'd3, PIX_CHECKER, 1'b0);
  endtask

  task automatic test_register_limits();
    run_frame(MODE_SPARE, width_word(4), 12'd2, PIX_RANDOM, 1'b0);
    run_frame(MODE_BLUR, 12'd0, 12'd3, PIX_RANDOM, 1'b0);
    run_frame(MODE_SOBEL, width_word(5), 12'd0, PIX_RANDOM, 1'b0);
    run_frame(MODE_SHARPEN, 12'h805, 12'd2, PIX_RANDOM, 1'b0);
    run_frame(MODE_SHARPEN, width_word(1), 12'd1, PIX_RANDOM, 1'b0);
    run_frame(MODE_BLUR, width_word(2), 12'd1, PIX_RANDOM, 1'b0);
    run_frame(MODE_SOBEL, width_word(1), 12'd24, PIX_RANDOM, 1'b0);
  endtask

  task automatic test_drain_noise();
    run_frame(MODE_BLUR, width_word(3), 12'd2, PIX_RANDOM, 1'b1);
    run_frame(MODE_SOBEL, width_word(1), 12'd3, PIX_RANDOM, 1'b1);
  endtask

  task automatic test_random_frames();
    int unsigned start, w, h, pick;
    start = stream_items;
    while (stream_items - start < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) w = 0;
      else if (pick == 1) w = $urandom_range(17, 64);
      else w = $urandom_range(1, 16);
      pick = $urandom_range(0, 19);
      if (pick == 0) h = 0;
      else if (pick == 1) h = $urandom_range(9, 20);
      else h = $urandom_range(1, 8);
      run_frame(2'($urandom_range(0, 3)), width_word(w), 12'(h),
                ($urandom_range(0, 7) == 0) ? PIX_CHECKER : PIX_RANDOM,
                $urandom_range(0, 3) == 0);
    end
  endtask

  initial begin
    rst = 1'b1;
    item = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_full_width();
    test_extreme_levels();
    test_register_limits();
    test_drain_noise();
    test_random_frames();
    settle();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
